// ===== src/e2h_pkg.sv =====
// Shared types, constants and tables for the equatorial to horizontal converter.
// Used by every module under src; depends on nothing else.
`timescale 1ns / 1ps

package e2h_pkg;

   // Angle scaling of the ports: degrees times 2^ANGLE_FRAC_BITS.
   localparam int ANGLE_FRAC_BITS = 12;
   localparam int CORDIC_STAGES   = 24;

   localparam int HALF_TURN_DEG = 180 << ANGLE_FRAC_BITS;
   localparam int FULL_TURN_DEG = 360 << ANGLE_FRAC_BITS;

   // Word widths.
   localparam int ANG_W   = 22;              // folded angle, signed degrees
   localparam int TURN_W  = 32;              // binary angle, 2^32 per turn
   localparam int CW_W    = 36;              // CORDIC x and y
   localparam int ZW_W    = 34;              // CORDIC angle accumulator
   localparam int Q_W     = 33;              // Q30 sine, cosine and products
   localparam int Q_FRAC  = 30;
   localparam int S_W     = 32;              // clamped altitude sine
   localparam int V_W     = 61;              // 1 - s^2 in Q60
   localparam int SQ_W    = 62;              // square root remainder and root
   localparam int SQRT_STAGES = 31;
   localparam int SQ_TOP  = 60;              // first trial bit of the root
   localparam int DEG_W   = 9 + ANGLE_FRAC_BITS;
   localparam int PROD_W  = TURN_W + DEG_W;

   localparam longint ONE_Q30      = 64'sd1 << Q_FRAC;
   localparam longint QUARTER_TURN = 64'sd1 << 30;
   localparam longint GAIN_Q30     = 64'sd652032874;
   localparam longint DEG_SCALE    = 64'sd360 << ANGLE_FRAC_BITS;

   // Degrees to turns: q = floor((m * 2^REM_SHIFT + 22) / 45), split as
   // m = 45 * quotient + remainder with the remainder part from a table.
   localparam int REM_SHIFT   = 29 - ANGLE_FRAC_BITS;
   localparam int RECIP_SHIFT = 27;
   localparam int RECIP_MUL   = (1 << RECIP_SHIFT) / 45;
   localparam int EST_W       = ANG_W - 5;

   typedef logic signed [ANG_W-1:0] ang_type;
   typedef logic [TURN_W-1:0]       turn_type;
   typedef logic signed [CW_W-1:0]  cw_type;
   typedef logic signed [ZW_W-1:0]  zw_type;
   typedef logic signed [Q_W-1:0]   q_type;

   // One CORDIC word handed from cell to cell; tag rides along.
   typedef struct packed {
      cw_type x;
      cw_type y;
      zw_type z;
      logic   tag;
   } cordic_word_type;

   // One square root word handed from cell to cell.
   typedef struct packed {
      logic [SQ_W-1:0] rem;
      logic [SQ_W-1:0] root;
   } sqrt_word_type;

   typedef logic [44:0][TURN_W-1:0] frac_tbl_type;

   function automatic frac_tbl_type frac_table();
      frac_tbl_type t;
      longint       v;
      for (int r = 0; r < 45; r++) begin
         v    = ((longint'(r) << REM_SHIFT) + 64'sd22) / 45;
         t[r] = v[TURN_W-1:0];
      end
      return t;
   endfunction

   localparam frac_tbl_type FRAC_TBL = frac_table();

   // Arctangent of 2^-i in binary angle units.
   localparam logic [0:31][31:0] ARCTAN_TURNS = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

endpackage

// ===== src/e2h_turn.sv =====
// Five-stage converter from scaled degrees to a 32-bit binary angle.
// Depends on e2h_pkg.
`timescale 1ns / 1ps

module e2h_turn import e2h_pkg::*; (
   input  logic     clock,
   input  logic     enable,
   input  ang_type  angle_i,
   output turn_type turn_o
);

   logic                   neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic [ANG_W-1:0]       mag1_ff, mag2_ff;
   logic [EST_W-1:0]       est_ff;
   logic [EST_W-1:0]       quo_ff;
   logic [5:0]             rem_ff;
   turn_type               sum_ff;
   turn_type               turn_ff;
   logic [2*ANG_W-1:0]     prod_in;
   logic [ANG_W-1:0]       r0_in;
   logic [63:0]            sum_in;

   always_comb begin
      prod_in = mag1_ff * ANG_W'(RECIP_MUL);
      r0_in   = mag2_ff - ANG_W'(est_ff) * ANG_W'(45);
      sum_in  = (64'(quo_ff) << REM_SHIFT) + 64'(FRAC_TBL[rem_ff]);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         // Magnitude and sign.
         neg1_ff <= angle_i[ANG_W-1];
         mag1_ff <= angle_i[ANG_W-1] ? ANG_W'(-angle_i) : ANG_W'(angle_i);
         // Quotient estimate by 45, at most one short.
         neg2_ff <= neg1_ff;
         mag2_ff <= mag1_ff;
         est_ff  <= prod_in[RECIP_SHIFT+EST_W-1:RECIP_SHIFT];
         // Correct the estimate and keep the remainder.
         neg3_ff <= neg2_ff;
         if (r0_in >= ANG_W'(45)) begin
            quo_ff <= est_ff + EST_W'(1);
            rem_ff <= 6'(r0_in - ANG_W'(45));
         end else begin
            quo_ff <= est_ff;
            rem_ff <= 6'(r0_in);
         end
         // Compose the turn magnitude.
         neg4_ff <= neg3_ff;
         sum_ff  <= sum_in[TURN_W-1:0];
         // Apply the sign.
         turn_ff <= neg4_ff ? (TURN_W'(0) - sum_ff) : sum_ff;
      end
   end

   assign turn_o = turn_ff;

endmodule

// ===== src/e2h_rot_cell.sv =====
// One stage of the rotation CORDIC that produces sine and cosine.
// Depends on e2h_pkg.
`timescale 1ns / 1ps

module e2h_rot_cell import e2h_pkg::*; (
   input  logic            clock,
   input  logic            enable,
   input  logic [4:0]      stage_idx,
   input  cordic_word_type word_i,
   output cordic_word_type word_o
);

   cordic_word_type word_ff, word_in;
   cw_type          xs, ys;
   zw_type          atan;

   // Rotate toward zero residual angle.
   always_comb begin
      xs      = word_i.x >>> stage_idx;
      ys      = word_i.y >>> stage_idx;
      atan    = {2'b00, ARCTAN_TURNS[stage_idx]};
      word_in = word_i;
      if (!word_i.z[ZW_W-1]) begin
         word_in.x = word_i.x - ys;
         word_in.y = word_i.y + xs;
         word_in.z = word_i.z - atan;
      end else begin
         word_in.x = word_i.x + ys;
         word_in.y = word_i.y - xs;
         word_in.z = word_i.z + atan;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         word_ff <= word_in;
      end
   end

   assign word_o = word_ff;

endmodule

// ===== src/e2h_vec_cell.sv =====
// One stage of the vectoring CORDIC that produces an arctangent.
// Depends on e2h_pkg.
`timescale 1ns / 1ps

module e2h_vec_cell import e2h_pkg::*; (
   input  logic            clock,
   input  logic            enable,
   input  logic [4:0]      stage_idx,
   input  cordic_word_type word_i,
   output cordic_word_type word_o
);

   cordic_word_type word_ff, word_in;
   cw_type          xs, ys;
   zw_type          atan;

   // Drive y toward zero, accumulating the angle.
   always_comb begin
      xs      = word_i.x >>> stage_idx;
      ys      = word_i.y >>> stage_idx;
      atan    = {2'b00, ARCTAN_TURNS[stage_idx]};
      word_in = word_i;
      if (!word_i.y[CW_W-1] && (word_i.y != '0)) begin
         word_in.x = word_i.x + ys;
         word_in.y = word_i.y - xs;
         word_in.z = word_i.z + atan;
      end else begin
         word_in.x = word_i.x - ys;
         word_in.y = word_i.y + xs;
         word_in.z = word_i.z - atan;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         word_ff <= word_in;
      end
   end

   assign word_o = word_ff;

endmodule

// ===== src/e2h_sqrt_cell.sv =====
// One digit step of the restoring integer square root.
// Depends on e2h_pkg.
`timescale 1ns / 1ps

module e2h_sqrt_cell import e2h_pkg::*; (
   input  logic          clock,
   input  logic          enable,
   input  logic [4:0]    stage_idx,
   input  sqrt_word_type word_i,
   output sqrt_word_type word_o
);

   sqrt_word_type   word_ff, word_in;
   logic [SQ_W-1:0] trial_bit;
   logic [SQ_W:0]   trial;

   // Try the next root bit and keep it if the remainder allows.
   always_comb begin
      trial_bit = SQ_W'(1) << (SQ_TOP - 2 * int'(stage_idx));
      trial     = {1'b0, word_i.root} + {1'b0, trial_bit};
      if ({1'b0, word_i.rem} >= trial) begin
         word_in.rem  = word_i.rem - trial[SQ_W-1:0];
         word_in.root = (word_i.root >> 1) + trial_bit;
      end else begin
         word_in.rem  = word_i.rem;
         word_in.root = word_i.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         word_ff <= word_in;
      end
   end

   assign word_o = word_ff;

endmodule

// ===== src/equatorial_to_horizontal.sv =====
// Top level of the equatorial to horizontal converter: fold, sine/cosine chains,
// products, square root and arctangent chains. Depends on e2h_pkg, e2h_turn and all e2h cells.
//
//   channel | dir | port group      | fields (low bit first)
//   req     | in  | req_tvalid/ready| latitude, longitude, declination, hour_angle
//   rsp     | out | rsp_tvalid/ready| altitude, azimuth
//
// One transaction enters per cycle while no result waits on rsp_tready.
// The pipeline is made of the three 24-cell sine/cosine chains, the 31-cell square
// root chain and the 24-cell arctangent chains, plus fold, degrees-to-turns, product and scale stages.
// Reset clears only the valid bits of the pipeline.
// The whole pipeline holds while a result waits on rsp_tready, bubbles included.
`timescale 1ns / 1ps

module equatorial_to_horizontal import e2h_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // latitude[19:0], longitude[40:20], declination[60:41], hour_angle[81:61]
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // altitude[19:0], azimuth[40:20]
   output logic [47:0] rsp_tdata
);

   localparam int TURN_LAT = 5;
   localparam int AUX_LEN  = 2 + SQRT_STAGES;
   localparam int LAT = 1 + TURN_LAT + CORDIC_STAGES + 1 + 3 + 2 + SQRT_STAGES + 1
                        + CORDIC_STAGES + 4;

   localparam logic signed [23:0] HALF_DEG = 24'(HALF_TURN_DEG);
   localparam logic signed [23:0] FULL_DEG = 24'(FULL_TURN_DEG);
   localparam logic signed [Q_W:0] ONE_S   = (Q_W+1)'(ONE_Q30);

   typedef struct packed {
      logic signed [S_W-1:0] s;
      q_type                 num;
      logic signed [Q_W:0]   den;
   } aux_type;

   function automatic q_type mul_q(q_type a, q_type b);
      logic signed [2*Q_W-1:0] p;
      p = a * b;
      return p[Q_FRAC+Q_W-1:Q_FRAC];
   endfunction

   function automatic cordic_word_type rot_start(turn_type t);
      cordic_word_type w;
      logic            flip;
      turn_type        adj;
      flip  = t[TURN_W-1] ^ t[TURN_W-2];
      adj   = flip ? {~t[TURN_W-1], t[TURN_W-2:0]} : t;
      w.x   = CW_W'(GAIN_Q30);
      w.y   = '0;
      w.z   = ZW_W'($signed(adj));
      w.tag = flip;
      return w;
   endfunction

   function automatic cordic_word_type vec_start(cw_type y, cw_type x);
      cordic_word_type w;
      w.tag = (x == '0) && (y == '0);
      w.x   = x;
      w.y   = y;
      w.z   = '0;
      if (x[CW_W-1]) begin
         if (!y[CW_W-1]) begin
            w.x = y;
            w.y = -x;
            w.z = ZW_W'(QUARTER_TURN);
         end else begin
            w.x = -y;
            w.y = x;
            w.z = -ZW_W'(QUARTER_TURN);
         end
      end
      return w;
   endfunction

   logic                   adv;
   logic [LAT-1:0]         vld_ff;
   logic                   east_ff [LAT-1];
   ang_type                lat_ff, dec_ff, p_ff;
   logic signed [19:0]     lat_f, dec_f;
   logic signed [23:0]     diff_in, p_in;
   logic                   east_in;
   turn_type               turn_w [3];
   cordic_word_type        rot_w [3][CORDIC_STAGES+1];
   q_type                  sin_ff [3];
   q_type                  cos_ff [3];
   q_type                  p1_ff, p2_ff, p3_ff, p4_ff, p5_ff, cp1_ff;
   q_type                  q1_ff, q2_ff, p1b_ff, p3b_ff, p4b_ff;
   logic signed [Q_W:0]    sum_in;
   logic signed [S_W-1:0]  s_ff;
   q_type                  num_ff;
   logic signed [Q_W:0]    den_ff;
   aux_type                aux_ff [AUX_LEN];
   logic signed [2*S_W-1:0] sqp_in;
   logic [V_W-1:0]         sq_ff;
   sqrt_word_type          sq0_ff;
   sqrt_word_type          sq_w [SQRT_STAGES+1];
   cordic_word_type        vec0_ff [2];
   cordic_word_type        vec_w [2][CORDIC_STAGES+1];
   zw_type                 za_alt, za_az;
   logic                   neg1_ff, neg2_ff, neg3_ff;
   logic [TURN_W-1:0]      mag_ff, zt_ff;
   logic [PROD_W-1:0]      prod_alt_ff, prod_az_ff;
   logic [PROD_W-1:0]      rnd_alt_in, rnd_az_in;
   logic [DEG_W-1:0]       alt_m_ff, az_m_ff;
   logic [19:0]            alt_ff;
   logic [20:0]            az_ff;

   // The whole pipeline moves unless the output register is held.
   assign adv        = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = {7'b0, az_ff, alt_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   // Fold longitude minus hour angle into a local hour angle and an east flag.
   always_comb begin
      lat_f   = req_tdata[19:0];
      dec_f   = req_tdata[60:41];
      diff_in = $signed({3'b000, req_tdata[40:20]}) - $signed({3'b000, req_tdata[81:61]});
      if (diff_in > HALF_DEG) begin
         p_in    = FULL_DEG - diff_in;
         east_in = 1'b1;
      end else if (diff_in < -HALF_DEG) begin
         p_in    = FULL_DEG + diff_in;
         east_in = 1'b0;
      end else if (diff_in > 24'sd0) begin
         p_in    = diff_in;
         east_in = 1'b0;
      end else if (diff_in < 24'sd0) begin
         p_in    = -diff_in;
         east_in = 1'b1;
      end else begin
         p_in    = '0;
         east_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lat_ff     <= ANG_W'(lat_f);
         dec_ff     <= ANG_W'(dec_f);
         p_ff       <= ANG_W'(p_in);
         east_ff[0] <= east_in;
         for (int j = 1; j < LAT - 1; j++) begin
            east_ff[j] <= east_ff[j-1];
         end
      end
   end

   // Degrees to turns, then sine and cosine chains: latitude, declination, hour angle.
   e2h_turn u_turn_lat (.clock(clock), .enable(adv), .angle_i(lat_ff), .turn_o(turn_w[0]));
   e2h_turn u_turn_dec (.clock(clock), .enable(adv), .angle_i(dec_ff), .turn_o(turn_w[1]));
   e2h_turn u_turn_p   (.clock(clock), .enable(adv), .angle_i(p_ff),   .turn_o(turn_w[2]));

   for (genvar g = 0; g < 3; g++) begin : g_rot
      assign rot_w[g][0] = rot_start(turn_w[g]);
      for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
         e2h_rot_cell u_cell (
            .clock     (clock),
            .enable    (adv),
            .stage_idx (5'(i)),
            .word_i    (rot_w[g][i]),
            .word_o    (rot_w[g][i+1])
         );
      end

      // Undo the half-turn fold.
      always_ff @(posedge clock) begin
         if (adv) begin
            sin_ff[g] <= rot_w[g][CORDIC_STAGES].tag ? Q_W'(-rot_w[g][CORDIC_STAGES].y)
                                                     : Q_W'(rot_w[g][CORDIC_STAGES].y);
            cos_ff[g] <= rot_w[g][CORDIC_STAGES].tag ? Q_W'(-rot_w[g][CORDIC_STAGES].x)
                                                     : Q_W'(rot_w[g][CORDIC_STAGES].x);
         end
      end
   end

   // Spherical products over three stages, then clamp the altitude sine.
   always_comb begin
      sum_in = (Q_W+1)'(p1b_ff) + (Q_W+1)'(q1_ff);
      if (sum_in > ONE_S) begin
         sum_in = ONE_S;
      end else if (sum_in < -ONE_S) begin
         sum_in = -ONE_S;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff  <= mul_q(sin_ff[1], sin_ff[0]);
         p2_ff  <= mul_q(cos_ff[0], cos_ff[1]);
         p3_ff  <= mul_q(sin_ff[1], cos_ff[0]);
         p4_ff  <= mul_q(cos_ff[1], sin_ff[2]);
         p5_ff  <= mul_q(cos_ff[1], sin_ff[0]);
         cp1_ff <= cos_ff[2];
         q1_ff  <= mul_q(p2_ff, cp1_ff);
         q2_ff  <= mul_q(p5_ff, cp1_ff);
         p1b_ff <= p1_ff;
         p3b_ff <= p3_ff;
         p4b_ff <= p4_ff;
         s_ff   <= S_W'(sum_in);
         num_ff <= p4b_ff;
         den_ff <= (Q_W+1)'(p3b_ff) - (Q_W+1)'(q2_ff);
      end
   end

   // Cosine of altitude as sqrt(1 - s^2); azimuth operands wait alongside.
   assign sqp_in = s_ff * s_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff       <= sqp_in[V_W-1:0];
         sq0_ff.rem  <= SQ_W'((V_W'(1) << (2 * Q_FRAC)) - sq_ff);
         sq0_ff.root <= '0;
         aux_ff[0]   <= '{s: s_ff, num: num_ff, den: den_ff};
         for (int j = 1; j < AUX_LEN; j++) begin
            aux_ff[j] <= aux_ff[j-1];
         end
      end
   end

   assign sq_w[0] = sq0_ff;
   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
      e2h_sqrt_cell u_cell (
         .clock     (clock),
         .enable    (adv),
         .stage_idx (5'(k)),
         .word_i    (sq_w[k]),
         .word_o    (sq_w[k+1])
      );
   end

   // Arctangent chains: altitude in lane 0, azimuth in lane 1.
   always_ff @(posedge clock) begin
      if (adv) begin
         vec0_ff[0] <= vec_start(CW_W'(aux_ff[AUX_LEN-1].s),
                                 CW_W'(sq_w[SQRT_STAGES].root));
         vec0_ff[1] <= vec_start(CW_W'(aux_ff[AUX_LEN-1].num),
                                 CW_W'(aux_ff[AUX_LEN-1].den));
      end
   end

   for (genvar g = 0; g < 2; g++) begin : g_vec
      assign vec_w[g][0] = vec0_ff[g];
      for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
         e2h_vec_cell u_cell (
            .clock     (clock),
            .enable    (adv),
            .stage_idx (5'(i)),
            .word_i    (vec_w[g][i]),
            .word_o    (vec_w[g][i+1])
         );
      end
   end

   // Turns back to scaled degrees, round half up, sign and mirror.
   always_comb begin
      za_alt     = vec_w[0][CORDIC_STAGES].tag ? '0 : vec_w[0][CORDIC_STAGES].z;
      za_az      = vec_w[1][CORDIC_STAGES].tag ? '0 : vec_w[1][CORDIC_STAGES].z;
      rnd_alt_in = prod_alt_ff + (PROD_W'(1) << (TURN_W - 1));
      rnd_az_in  = prod_az_ff + (PROD_W'(1) << (TURN_W - 1));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         neg1_ff     <= za_alt[ZW_W-1];
         mag_ff      <= za_alt[ZW_W-1] ? TURN_W'(-za_alt) : TURN_W'(za_alt);
         zt_ff       <= za_az[TURN_W-1:0];
         neg2_ff     <= neg1_ff;
         prod_alt_ff <= PROD_W'(mag_ff) * PROD_W'(DEG_SCALE);
         prod_az_ff  <= PROD_W'(zt_ff) * PROD_W'(DEG_SCALE);
         neg3_ff     <= neg2_ff;
         alt_m_ff    <= rnd_alt_in[PROD_W-1:TURN_W];
         az_m_ff     <= rnd_az_in[PROD_W-1:TURN_W];
         alt_ff      <= neg3_ff ? 20'(DEG_W'(0) - alt_m_ff) : 20'(alt_m_ff);
         az_ff       <= east_ff[LAT-2] ? 21'(DEG_W'(FULL_TURN_DEG) - az_m_ff) : 21'(az_m_ff);
      end
   end

   // Checks on the result range and on reset.
   localparam logic signed [19:0] ALT_LIMIT = 20'((90 << ANGLE_FRAC_BITS) + 1);

   a_alt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[19:0]) <= ALT_LIMIT &&
                      $signed(rsp_tdata[19:0]) >= -ALT_LIMIT))
      else $error("altitude beyond a quarter turn");

   a_az_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[40:20] <= 21'(FULL_TURN_DEG)))
      else $error("azimuth beyond a full turn");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result transaction shown right after reset");

endmodule

// ===== test/equatorial_to_horizontal_tb.sv =====
// Self-checking bench for the equatorial to horizontal converter.
// Depends on e2h_pkg and the equatorial_to_horizontal top level.
`timescale 1ns / 1ps

// Expected results of accepted input transactions, oldest first.
class horizon_board;
   logic [40:0] pending_fixes[$];
   int errors;

   function new();
      errors = 0;
   endfunction

   function void note_position(logic [40:0] fix);
      pending_fixes.push_back(fix);
   endfunction

   function void check_fix(logic [47:0] got);
      logic [40:0] want;
      if (pending_fixes.size() == 0) begin
         $display("%0t: unexpected result alt %h az %h", $time, got[19:0], got[40:20]);
         errors++;
         return;
      end
      want = pending_fixes.pop_front();
      if (got[19:0] !== want[19:0]) begin
         $display("%0t: altitude expected %h actual %h", $time, want[19:0], got[19:0]);
         errors++;
      end
      if (got[40:20] !== want[40:20]) begin
         $display("%0t: azimuth expected %h actual %h", $time, want[40:20], got[40:20]);
         errors++;
      end
   endfunction
endclass

module equatorial_to_horizontal_tb;
   import e2h_pkg::*;

   localparam logic [31:0] ATAN_TAB [0:31] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000};
   localparam int FRAC = 12;
   localparam int STAGES = 24;
   localparam longint UNIT = 64'sd1 << 30;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;

   horizon_board board = new();
   longint cycles = 0;
   bit stim_done = 0;

   equatorial_to_horizontal dut (.*);

   always #10 clock = ~clock;

   // Signed arithmetic shift toward minus infinity.
   function automatic longint fshift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint mulq(longint a, longint b);
      return (a * b) >>> 30;
   endfunction

   function automatic logic [31:0] to_turns(longint a);
      longint m;
      logic [63:0] q;
      m = a < 0 ? -a : a;
      q = ((m << (32 - FRAC)) + 180) / 360;
      return a < 0 ? 32'(0 - q[31:0]) : q[31:0];
   endfunction

   function automatic longint turns_to_deg(longint m);
      logic [63:0] p;
      p = ((64'(m) * 360) << FRAC) + (64'd1 << 31);
      return longint'(p >> 32);
   endfunction

   task automatic rotate(input logic [31:0] ang, output longint s, output longint c);
      bit flip;
      longint x, y, z, xs, ys;
      flip = ((ang + 32'h40000000) & 32'h80000000) != 0;
      x = 652032874;
      y = 0;
      if (flip) ang = ang + 32'h80000000;
      z = longint'(ang);
      if (z >= (64'sd1 << 31)) z -= 64'sd1 << 32;
      for (int i = 0; i < STAGES; i++) begin
         xs = fshift(x, i);
         ys = fshift(y, i);
         if (z >= 0) begin
            x -= ys; y += xs; z -= ATAN_TAB[i];
         end else begin
            x += ys; y -= xs; z += ATAN_TAB[i];
         end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endtask

   function automatic longint vector_angle(longint y, longint x);
      longint z, t, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = UNIT;
         end else begin
            t = x; x = -y; y = t; z = -UNIT;
         end
      end
      for (int i = 0; i < STAGES; i++) begin
         xs = fshift(x, i);
         ys = fshift(y, i);
         if (y > 0) begin
            x += ys; y -= xs; z += ATAN_TAB[i];
         end else begin
            x -= ys; y += xs; z -= ATAN_TAB[i];
         end
      end
      return z;
   endfunction

   function automatic logic [63:0] root_of(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   // Altitude and azimuth for one observation.
   task automatic predict_fix(input logic [87:0] d, output logic [40:0] fix);
      longint lat, lon, dec, gha, diff, p, sl, cl, sd, cd, sp, cp, s, c, za, alt, az;
      longint num, den, half, full;
      bit east;
      logic [31:0] zt;
      half = 180 << FRAC;
      full = 360 << FRAC;
      lat = longint'(signed'(d[19:0]));
      lon = longint'(d[40:20]);
      dec = longint'(signed'(d[60:41]));
      gha = longint'(d[81:61]);
      diff = lon - gha;
      if (diff > half) begin
         p = full - diff; east = 1;
      end else if (-diff > half) begin
         p = full + diff; east = 0;
      end else if (diff > 0) begin
         p = diff; east = 0;
      end else if (diff < 0) begin
         p = -diff; east = 1;
      end else begin
         p = 0; east = 0;
      end
      rotate(to_turns(lat), sl, cl);
      rotate(to_turns(dec), sd, cd);
      rotate(to_turns(p), sp, cp);
      s = mulq(sd, sl) + mulq(mulq(cl, cd), cp);
      if (s > UNIT) s = UNIT;
      if (s < -UNIT) s = -UNIT;
      c = longint'(root_of(64'(UNIT * UNIT - s * s)));
      za = vector_angle(s, c);
      alt = turns_to_deg(za < 0 ? -za : za);
      if (za < 0) alt = -alt;
      num = mulq(cd, sp);
      den = mulq(sd, cl) - mulq(mulq(cd, sl), cp);
      zt = 32'(vector_angle(num, den));
      az = turns_to_deg(longint'(zt));
      if (east) az = full - az;
      fix = {21'(az), 20'(alt)};
   endtask

   // Receiver: checks at the rising edge, stalls on its own pattern.
   int stall_mode = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) board.check_fix(rsp_tdata);
   end
   always @(negedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ($urandom_range(0, 1) != 0);
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Sends one observation; waits for acceptance.
   task automatic send_position(logic [19:0] lat, logic [20:0] lon,
                                logic [19:0] dec, logic [20:0] gha);
      logic [40:0] fix;
      req_tdata  <= {6'd0, gha, dec, lon, lat};
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_fix({6'd0, gha, dec, lon, lat}, fix);
      board.note_position(fix);
      @(negedge clock);
   endtask

   task automatic idle_gap();
      int n;
      n = $urandom_range(1, 6);
      req_tvalid <= 0;
      repeat (n) @(negedge clock);
   endtask

   function automatic logic [19:0] rnd_lat();
      case ($urandom_range(0, 5))
         0: return 20'($urandom);
         1: return 20'(int'($urandom_range(0, 20)) - 10);
         default: return 20'(int'($urandom_range(0, 737280)) - 368640);
      endcase
   endfunction

   function automatic logic [20:0] rnd_lon();
      case ($urandom_range(0, 5))
         0: return 21'($urandom);
         default: return 21'($urandom_range(0, 1474559));
      endcase
   endfunction

   initial begin
      int burst;
      logic [20:0] lon;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // Extremes, poles, zenith, equal longitude and hour angle, fold edges.
      send_position(20'd0, 21'd0, 20'd0, 21'd0);
      send_position(20'd368640, 21'd100, 20'd368640, 21'd100);
      send_position(-20'sd368640, 21'd0, -20'sd368640, 21'd1474559);
      send_position(20'd368640, 21'd737280, 20'd0, 21'd0);
      send_position(20'd0, 21'd0, 20'd0, 21'd737280);
      send_position(20'd4096, 21'd737281, 20'd8192, 21'd0);
      send_position(20'd4096, 21'd0, 20'd8192, 21'd737281);
      send_position(20'd204800, 21'd1474559, -20'sd40960, 21'd0);
      send_position(20'd204800, 21'd409600, 20'd204800, 21'd409600);
      send_position(20'h7FFFF, 21'h1FFFFF, 20'h80000, 21'h1FFFFF);
      send_position(20'h80000, 21'h1FFFFF, 20'h7FFFF, 21'd0);
      send_position(20'hFFFFF, 21'd1, 20'd1, 21'd2);
      send_position(-20'sd122880, 21'd3, 20'd122880, 21'd1474556);
      idle_gap();
      // Random bursts with gaps.
      for (int k = 0; k < 900;) begin
         burst = $urandom_range(1, 40);
         for (int j = 0; j < burst; j++) begin
            lon = rnd_lon();
            if ($urandom_range(0, 15) == 0)
               send_position(rnd_lat(), lon, rnd_lat(), lon);
            else
               send_position(rnd_lat(), lon, rnd_lat(), rnd_lon());
            k++;
         end
         if ($urandom_range(0, 3) != 0) idle_gap();
      end
      req_tvalid <= 0;
      stim_done = 1;
   end

   // End of run and watchdog.
   initial begin
      wait (stim_done);
      while (board.pending_fixes.size() != 0 && cycles < 400000) @(posedge clock);
      repeat (200) @(posedge clock);
      if (cycles >= 400000) begin
         $display("end of test: mismatches");
      end else if (board.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      wait (cycles >= 500000);
      $display("end of test: mismatches");
      $finish;
   end
endmodule
